FILE: hdl/ide_pkg.sv
// Shared constants, payload structs and control types for the indexed deque engine.
package ide_pkg;

  localparam int DEPTH      = 64;
  localparam int ELEM_WIDTH = 32;

  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 7;
  localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  // read-data reduction: groups of cells ORed and registered, then the groups ORed
  localparam int GRP  = 8;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5,
    OP_INSERT     = 3'd6,
    OP_DELETE     = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    C_HOLD       = 2'd0,
    C_LOAD       = 2'd1,
    C_FROM_LEFT  = 2'd2,
    C_FROM_RIGHT = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      rd_sel;
  } cell_ctl_t;

  typedef struct packed {
    op_t              operation;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } ide_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] result_value;
    logic [ST_W-1:0]  status;
    logic [LEN_W-1:0] length;
  } ide_out_t;

endpackage

FILE: hdl/indexed_deque_engine.sv
// Indexed deque engine: top level with request decode, the cell chain and result path.
//
// An ordered list of up to DEPTH elements held in a chain of cells, one element
// per cell, with logical position 0 in cell 0. The cells update at the edge that
// accepts a request beat, so push, pop, write, insert and delete modify the list
// at acceptance, and a read leaves it as it is; insert and delete move every
// element behind the index by one cell through the neighbor links. Each request
// returns one result beat: the selected element is ORed in groups of eight cells
// registered at the accepting edge, then the groups are combined into the output
// register, which holds the beat while the result side stalls.
// A new request is accepted every cycle while the result side keeps taking beats;
// a stalled result lets one more request in and then stalls the input. No clearing
// is needed after reset: only cells below the current length are ever read.
module indexed_deque_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ide_pkg::ide_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ide_pkg::ide_out_t out_data
);
  import ide_pkg::*;

  typedef enum logic [1:0] {
    M_NONE  = 2'd0,
    M_WRITE = 2'd1,
    M_OPEN  = 2'd2,
    M_CLOSE = 2'd3
  } mode_t;

  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  pend_r;
  logic                  out_valid_r;
  ide_out_t              out_r;
  ide_out_t              out_nxt;
  logic [ELEM_WIDTH-1:0] grp_r   [NGRP];
  logic [ELEM_WIDTH-1:0] grp_nxt [NGRP];
  logic [ST_W-1:0]       st_r;
  logic [LEN_W-1:0]      len_r;

  logic                  acc;
  logic                  move;
  logic [CMP_W-1:0]      cmp_idx;
  logic [CMP_W-1:0]      cmp_cnt;
  logic                  empty;
  logic                  full;
  status_t               st;
  mode_t                 mode;
  logic [POS_W-1:0]      pos;
  logic                  rd_en;
  logic [POS_W-1:0]      rd_pos;
  logic [ELEM_WIDTH-1:0] new_val;
  logic [ELEM_WIDTH-1:0] red;

  cell_ctl_t             ctl    [DEPTH];
  logic [ELEM_WIDTH-1:0] cell_q [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_val [DEPTH];

  assign move     = pend_r && (!out_valid_r || !out_stall);
  assign in_stall = pend_r && !move;
  assign acc      = in_valid && !in_stall;
  assign new_val  = ELEM_WIDTH'(in_data.value);

  // request decode and checks
  always_comb begin
    cmp_idx = CMP_W'(in_data.index);
    cmp_cnt = CMP_W'(cnt_r);
    empty   = (cnt_r == '0);
    full    = (cnt_r == CNT_W'(DEPTH));
    st      = ST_OK;
    mode    = M_NONE;
    pos     = '0;
    rd_en   = 1'b0;
    rd_pos  = '0;
    cnt_nxt = cnt_r;
    unique case (in_data.operation)
      OP_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          mode    = M_WRITE;
          pos     = cnt_r[POS_W-1:0];
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          st = ST_RANGE;
        end else begin
          rd_en   = 1'b1;
          rd_pos  = POS_W'(cnt_r - CNT_W'(1));
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          mode    = M_OPEN;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st = ST_RANGE;
        end else begin
          mode    = M_CLOSE;
          rd_en   = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (cmp_idx >= cmp_cnt) begin
          st = ST_RANGE;
        end else begin
          rd_en  = 1'b1;
          rd_pos = POS_W'(in_data.index);
        end
      end
      OP_WRITE: begin
        if (cmp_idx >= cmp_cnt) begin
          st = ST_RANGE;
        end else begin
          mode = M_WRITE;
          pos  = POS_W'(in_data.index);
        end
      end
      OP_INSERT: begin
        // range is checked before fullness
        if (cmp_idx > cmp_cnt) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          mode    = M_OPEN;
          pos     = POS_W'(in_data.index);
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (cmp_idx >= cmp_cnt) begin
          st = ST_RANGE;
        end else begin
          mode    = M_CLOSE;
          pos     = POS_W'(in_data.index);
          rd_en   = 1'b1;
          rd_pos  = POS_W'(in_data.index);
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: st = ST_OK;
    endcase
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam logic [POS_W-1:0] KPOS = POS_W'(k);
    logic [ELEM_WIDTH-1:0] left_in;
    logic [ELEM_WIDTH-1:0] right_in;

    if (k == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_q[k-1];
    end

    // last cell has no right neighbor; it falls beyond the length after a close
    if (k == DEPTH - 1) begin : g_last
      assign right_in = cell_q[k];
    end else begin : g_mid_r
      assign right_in = cell_q[k+1];
    end

    always_comb begin
      ctl[k].cmd    = C_HOLD;
      ctl[k].rd_sel = rd_en && (rd_pos == KPOS);
      if (acc) begin
        unique case (mode)
          M_WRITE: begin
            if (KPOS == pos) ctl[k].cmd = C_LOAD;
          end
          M_OPEN: begin
            if (KPOS == pos) begin
              ctl[k].cmd = C_LOAD;
            end else if (KPOS > pos) begin
              ctl[k].cmd = C_FROM_LEFT;
            end
          end
          M_CLOSE: begin
            if (KPOS >= pos) ctl[k].cmd = C_FROM_RIGHT;
          end
          default: ctl[k].cmd = C_HOLD;
        endcase
      end
    end

    ide_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[k]),
      .load_val  (new_val),
      .left_val  (left_in),
      .right_val (right_in),
      .q         (cell_q[k]),
      .rd_val    (rd_val[k])
    );
  end

  // first level of the read-out OR: one group of cells each, pre-update values
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < DEPTH) grp_nxt[g] = grp_nxt[g] | rd_val[g * GRP + j];
      end
    end
  end

  always_comb begin
    red = '0;
    for (int g = 0; g < NGRP; g++) begin
      red = red | grp_r[g];
    end
    out_nxt.result_value = VAL_W'(red);
    out_nxt.status       = st_r;
    out_nxt.length       = len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) cnt_r <= cnt_nxt;
      if (acc) begin
        pend_r <= 1'b1;
      end else if (move) begin
        pend_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      grp_r <= grp_nxt;
      st_r  <= st;
      len_r <= LEN_W'(cnt_nxt);
    end
    if (move) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hdl/ide_cell.sv
// One storage cell of the element chain: holds, loads, or takes a neighbor's element.
module ide_cell (
  input  logic                           clk,
  input  ide_pkg::cell_ctl_t             ctl,
  input  logic [ide_pkg::ELEM_WIDTH-1:0] load_val,
  input  logic [ide_pkg::ELEM_WIDTH-1:0] left_val,
  input  logic [ide_pkg::ELEM_WIDTH-1:0] right_val,
  output logic [ide_pkg::ELEM_WIDTH-1:0] q,
  output logic [ide_pkg::ELEM_WIDTH-1:0] rd_val
);
  import ide_pkg::*;

  logic [ELEM_WIDTH-1:0] elem_r;
  logic [ELEM_WIDTH-1:0] elem_nxt;

  always_comb begin
    unique case (ctl.cmd)
      C_HOLD:       elem_nxt = elem_r;
      C_LOAD:       elem_nxt = load_val;
      C_FROM_LEFT:  elem_nxt = left_val;
      C_FROM_RIGHT: elem_nxt = right_val;
      default:      elem_nxt = elem_r;
    endcase
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  assign q      = elem_r;
  assign rd_val = ctl.rd_sel ? elem_r : '0;

endmodule

FILE: test/ide_checker.sv
// Checker for the indexed deque engine: shadows the list, predicts every result beat, compares.
`timescale 1ns / 1ps

module ide_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  ide_pkg::ide_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  ide_pkg::ide_out_t out_data,
  output int                fail_count,
  output int                pending,
  output int                list_len
);
  import ide_pkg::*;

  logic [ELEM_WIDTH-1:0] shadow_elems [DEPTH];
  int                    shadow_len;
  ide_out_t              due_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    list_len   = 0;
    shadow_len = 0;
  end

  // Applies one request to the shadow list and returns the beat it should produce.
  function automatic ide_out_t apply_request(input ide_in_t req);
    ide_out_t              res;
    int                    pos;
    int                    k;
    logic [ELEM_WIDTH-1:0] v;
    res = '0;
    v   = req.value[ELEM_WIDTH-1:0];
    // push/pop are insert/delete at a fixed end
    case (req.operation)
      OP_PUSH_BACK:  pos = shadow_len;
      OP_PUSH_FRONT: pos = 0;
      OP_POP_BACK:   pos = shadow_len - 1;
      OP_POP_FRONT:  pos = 0;
      default:       pos = int'(req.index);
    endcase
    case (req.operation)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        // range is checked ahead of fullness
        if (pos > shadow_len) begin
          res.status = ST_RANGE;
        end else if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (k = shadow_len; k > pos; k--) shadow_elems[k] = shadow_elems[k-1];
          shadow_elems[pos] = v;
          shadow_len++;
        end
      end
      OP_POP_BACK, OP_POP_FRONT, OP_DELETE: begin
        if (pos < 0 || pos >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          res.result_value = VAL_W'(shadow_elems[pos]);
          for (k = pos; k + 1 < shadow_len; k++) shadow_elems[k] = shadow_elems[k+1];
          shadow_len--;
        end
      end
      OP_READ: begin
        if (pos >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          res.result_value = VAL_W'(shadow_elems[pos]);
        end
      end
      default: begin
        if (pos >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          shadow_elems[pos] = v;
        end
      end
    endcase
    res.length = LEN_W'(shadow_len);
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input ide_out_t want, input ide_out_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected value %h status %0d length %0d, ",
               $realtime, what, want.result_value, want.status, want.length,
               "got value %h status %0d length %0d",
               got.result_value, got.status, got.length);
    end
  endtask

  always @(posedge clk) begin
    ide_out_t want;
    if (!rst_n) begin
      shadow_len = 0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          flag_mismatch("beat with nothing outstanding", '0, out_data);
        end else begin
          want = due_results.pop_front();
          if (out_data.result_value !== want.result_value ||
              out_data.status !== want.status ||
              out_data.length !== want.length) begin
            flag_mismatch("result beat mismatch", want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(apply_request(in_data));
      end
    end
    pending  = due_results.size();
    list_len = shadow_len;
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for the indexed deque engine: clock, reset, request and stall stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
  import ide_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int LONG_HOLD    = 150;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ide_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ide_out_t out_data;
  int       fail_count;
  int       pending;
  int       list_len;
  int       fill_goal;

  indexed_deque_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ide_checker check_u (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .list_len   (list_len)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[indexed_deque_engine] ERROR");
    $finish;
  end

  function automatic ide_in_t make_req(input op_t op, input int idx,
                                       input logic [VAL_W-1:0] v);
    ide_in_t r;
    r.operation = op;
    r.index     = IDX_W'(idx);
    r.value     = v;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-formed requests steering the length toward fill_goal, plus some noise.
  function automatic ide_in_t pick_request(input int len);
    op_t op;
    int  idx;
    int  roll;
    roll = $urandom_range(0, 99);
    idx  = 0;
    if (roll < 8) begin
      op  = op_t'($urandom_range(0, 7));
      idx = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH + 1, 127)
                                        : $urandom_range(0, DEPTH);
    end else if (len == DEPTH && roll < 25) begin
      // growth attempts on a full list, some with an index past the end
      if (roll < 15) begin
        op  = OP_INSERT;
        idx = (roll < 11) ? $urandom_range(DEPTH + 1, 127) : $urandom_range(0, DEPTH);
      end else begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end
    end else if (roll < 45 || len == fill_goal) begin
      op  = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
      idx = (len == 0 || $urandom_range(0, 19) == 0) ? $urandom_range(len, DEPTH)
                                                    : $urandom_range(0, len - 1);
    end else if (len < fill_goal) begin
      case ($urandom_range(0, 2))
        0:       op = OP_PUSH_BACK;
        1:       op = OP_PUSH_FRONT;
        default: begin
          op  = OP_INSERT;
          idx = $urandom_range(0, len);
        end
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       op = OP_POP_BACK;
        1:       op = OP_POP_FRONT;
        default: begin
          op  = OP_DELETE;
          idx = $urandom_range(0, len - 1);
        end
      endcase
    end
    return make_req(op, idx, rand_value());
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer(input ide_in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int sent;
    int burst;
    int gap;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    fill_goal = DEPTH;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list
    offer(make_req(OP_POP_BACK, 0, 32'h1111_1111));
    offer(make_req(OP_POP_FRONT, 0, 32'h2222_2222));
    offer(make_req(OP_READ, 0, 32'h0));
    offer(make_req(OP_WRITE, 0, 32'h3333_3333));
    offer(make_req(OP_DELETE, 0, 32'h0));
    offer(make_req(OP_INSERT, 1, 32'h4444_4444));
    // insert at the length appends
    offer(make_req(OP_INSERT, 0, 32'hA5A5_0001));
    offer(make_req(OP_PUSH_BACK, 0, 32'hFFFF_FFFF));
    offer(make_req(OP_PUSH_FRONT, 0, 32'h0000_0000));
    offer(make_req(OP_READ, 2, 32'h0));
    offer(make_req(OP_READ, 3, 32'h0));
    offer(make_req(OP_READ, 64, 32'h0));
    offer(make_req(OP_WRITE, 1, 32'h5555_5555));
    offer(make_req(OP_INSERT, 3, 32'hAAAA_AAAA));
    offer(make_req(OP_INSERT, 1, 32'h1234_5678));
    offer(make_req(OP_READ, 127, 32'hFFFF_FFFF));
    offer(make_req(OP_DELETE, 4, 32'h0));
    offer(make_req(OP_DELETE, 0, 32'h0));
    offer(make_req(OP_POP_FRONT, 0, 32'h0));
    offer(make_req(OP_POP_BACK, 0, 32'h0));
    offer(make_req(OP_READ, 0, 32'h0));
    offer(make_req(OP_DELETE, 0, 32'h0));
    offer(make_req(OP_WRITE, 127, 32'hDEAD_BEEF));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      if (sent > 0) begin
        case ($urandom_range(0, 3))
          0:       fill_goal = 0;
          1:       fill_goal = DEPTH;
          default: fill_goal = $urandom_range(0, DEPTH);
        endcase
      end
      repeat (burst) begin
        offer(pick_request(list_len));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("[indexed_deque_engine] OK");
    end else begin
      $display("[indexed_deque_engine] ERROR");
    end
    $finish;
  end

  // Result-side stall pattern, with one long hold-off to back up the input.
  initial begin
    int cyc;
    int mode;
    int span;
    bit held;
    out_stall = 1'b0;
    cyc       = 0;
    held      = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && cyc >= 400) begin
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        held = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 4) != 0);
          default: out_stall <= ~out_stall;
        endcase
        cyc++;
      end
    end
  end

endmodule

FILE: sim.f
hdl/ide_pkg.sv
hdl/ide_cell.sv
hdl/indexed_deque_engine.sv
test/ide_checker.sv
test/tb_top.sv
